// ----- hdl/aesb_pkg.sv -----
// aesb_pkg: shared constants and functions for the aes-128 block encryptor
// holds the sbox table, the two built-in keys and gf/round helper functions
// no dependencies
`default_nettype none
package aesb_pkg;

  localparam int unsigned NumRounds = 10;

  localparam logic [127:0] KeyU = 128'h71336275_5e74316e_71665a28_70662431;
  localparam logic [127:0] KeyD = 128'h48404346_6b526e7a_404b4174_424a7032;

  localparam logic [2047:0] SboxFlat = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  function automatic logic [7:0] sbox(input logic [7:0] x);
    sbox = SboxFlat[2047 - 8 * x -: 8];
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit word, byte 0 most significant
  function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
    byte_of = w[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = sbox(byte_of(s, 4 * ((c + r) % 4) + r));
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(s, 4 * c);
      a1 = byte_of(s, 4 * c + 1);
      a2 = byte_of(s, 4 * c + 2);
      a3 = byte_of(s, 4 * c + 3);
      b0 = gf_dbl(a0);
      b1 = gf_dbl(a1);
      b2 = gf_dbl(a2);
      b3 = gf_dbl(a3);
      t[127 - 32 * c -: 32] = {b0 ^ b1 ^ a1 ^ a2 ^ a3, a0 ^ b1 ^ b2 ^ a2 ^ a3,
                               a0 ^ a1 ^ b2 ^ b3 ^ a3, b0 ^ a0 ^ a1 ^ a2 ^ b3};
    end
    mix_cols = t;
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// ----- hdl/aes128_block_encrypt.sv -----
// aes128_block_encrypt: aes-128 encryptor as a row of ten round cells
// depends on aesb_pkg and aesb_round_cell
//
// channel  | ports                               | handshake
// input    | key_select, plain_hi, plain_lo      | start, busy (never high)
// result   | cipher_hi, cipher_lo                | done strobe, one cycle
//
// one word enters every cycle; each of the ten cells holds one round
// a word passes the input whitening register, then the ten round cells
// rst clears only the valid bits; data registers carry no reset
// the receiver cannot stall, so busy stays low
`default_nettype none
module aes128_block_encrypt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        key_select,
  input  wire logic [63:0] plain_hi,
  input  wire logic [63:0] plain_lo,
  output logic             done,
  output logic [63:0]      cipher_hi,
  output logic [63:0]      cipher_lo
);
  localparam int unsigned N = aesb_pkg::NumRounds;

  logic [N:0]         v;
  logic [127:0]       st [0:N];
  logic [127:0]       ky [0:N];
  logic [7:0]         rc [0:N-1];
  logic [127:0]       key0;

  assign busy = 1'b0;
  assign key0 = key_select ? aesb_pkg::KeyD : aesb_pkg::KeyU;

  // stage 0: initial add round key
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= start;
    end
    st[0] <= {plain_hi, plain_lo} ^ key0;
    ky[0] <= key0;
  end

  // round constants double along the row
  assign rc[0] = 8'h01;
  for (genvar g = 1; g < N; g++) begin : g_rc
    assign rc[g] = aesb_pkg::gf_dbl(rc[g-1]);
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    aesb_round_cell u_cell (
      .clk(clk), .rst(rst), .last(g == N - 1), .rcon(rc[g]),
      .in_valid(v[g]), .in_state(st[g]), .in_key(ky[g]),
      .out_valid(v[g+1]), .out_state(st[g+1]), .out_key(ky[g+1])
    );
  end

  assign done = v[N];
  assign cipher_hi = st[N][127:64];
  assign cipher_lo = st[N][63:0];

`ifndef ASSERT_OFF
  a_busy_low: assert property (@(posedge clk) busy == 1'b0) else $error("busy high");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    v[0] |=> ##9 done) else $error("word lost in cell row");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !v[0] |=> ##9 !done) else $error("spurious done");
`endif
endmodule
`default_nettype wire

// ----- hdl/aesb_round_cell.sv -----
// aesb_round_cell: one cipher round with its key schedule step, registered
// depends on aesb_pkg
`default_nettype none
module aesb_round_cell (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         last,
  input  wire logic [7:0]   rcon,
  input  wire logic         in_valid,
  input  wire logic [127:0] in_state,
  input  wire logic [127:0] in_key,
  output logic              out_valid,
  output logic [127:0]      out_state,
  output logic [127:0]      out_key
);
  logic [127:0] key_next;
  logic [127:0] ss;
  logic [127:0] state_next;

  always_comb begin
    key_next = aesb_pkg::next_key(in_key, rcon);
    ss = aesb_pkg::sub_shift(in_state);
    state_next = (last ? ss : aesb_pkg::mix_cols(ss)) ^ key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_state <= state_next;
    out_key <= key_next;
  end
endmodule
`default_nettype wire
